// ===== rtl/pckdec_pkg.sv =====
// shared types, constants and helpers of the packed image decompressor
package pckdec_pkg;

  localparam int unsigned MaxRowWidthDef = 4096;
  localparam int unsigned HeaderBits     = 6;
  localparam int unsigned RowWidthW      = 13;
  localparam int unsigned TotalW         = 25;
  localparam int unsigned CfgDataW       = 25;
  localparam logic [RowWidthW-1:0] RowWidthRst = 13'd3450;

  // configuration register indexes
  localparam logic CFG_ROW_WIDTH    = 1'b0;
  localparam logic CFG_TOTAL_PIXELS = 1'b1;

  // neighbour read selector
  typedef enum logic [1:0] {
    NBR_A = 2'd0,
    NBR_B = 2'd1,
    NBR_C = 2'd2
  } nbr_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic bit_step;
    logic rd;
    nbr_e rd_idx;
    logic cap;
    logic emit;
    logic flush_last;
  } pck_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic complete;
    logic bits_left;
    logic pix_req;
    logic need_nbr;
    logic grp_full;
    logic grp_empty;
    logic out_free;
  } pck_stat_t;

  // field width of a run, from the header code
  function automatic logic [5:0] field_width_of(input logic [2:0] code);
    logic [5:0] w;
    case (code)
      3'd0:    w = 6'd0;
      3'd1:    w = 6'd4;
      3'd2:    w = 6'd5;
      3'd3:    w = 6'd6;
      3'd4:    w = 6'd7;
      3'd5:    w = 6'd8;
      3'd6:    w = 6'd16;
      default: w = 6'd32;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/pck_stream_if.sv =====
// byte and pixel group channel interfaces
interface pck_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       new_image;

  modport source (output valid, stream_byte, new_image, input ready);
  modport sink (input valid, stream_byte, new_image, output ready);
endinterface

interface pck_group_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_a;
  logic [15:0] pixel_b;
  logic [15:0] pixel_c;
  logic [15:0] pixel_d;
  logic [2:0]  pixel_count;
  logic        last_of_byte;
  logic        image_done;

  modport source (output valid, pixel_a, pixel_b, pixel_c, pixel_d, pixel_count,
                  last_of_byte, image_done, input ready);
  modport sink (input valid, pixel_a, pixel_b, pixel_c, pixel_d, pixel_count,
                last_of_byte, image_done, output ready);
endinterface

// ===== rtl/pckdec_ctrl.sv =====
// sequencing state machine of the decompressor
module pckdec_ctrl
  import pckdec_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  pck_stat_t stat_i,
  output pck_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_RUN, S_RDA, S_RDB, S_RDC, S_CAPC, S_EMIT, S_END
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_idx = NBR_A;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_RUN;
        end
      end
      S_RUN: begin
        if (stat_i.complete) begin
          state_d = S_END;
        end else if (stat_i.pix_req) begin
          state_d = stat_i.need_nbr ? S_RDA : S_EMIT;
        end else if (stat_i.bits_left) begin
          cmd_o.bit_step = 1'b1;
        end else begin
          state_d = S_END;
        end
      end
      S_RDA: begin
        cmd_o.rd     = 1'b1;
        cmd_o.rd_idx = NBR_A;
        state_d      = S_RDB;
      end
      S_RDB: begin
        cmd_o.rd     = 1'b1;
        cmd_o.rd_idx = NBR_B;
        cmd_o.cap    = 1'b1;
        state_d      = S_RDC;
      end
      S_RDC: begin
        cmd_o.rd     = 1'b1;
        cmd_o.rd_idx = NBR_C;
        cmd_o.cap    = 1'b1;
        state_d      = S_CAPC;
      end
      S_CAPC: begin
        cmd_o.cap = 1'b1;
        state_d   = S_EMIT;
      end
      S_EMIT: begin
        if (!stat_i.grp_full || stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_RUN;
        end
      end
      S_END: begin
        if (stat_i.grp_empty) begin
          state_d = S_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.flush_last = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/pckdec_datapath.sv =====
// bit unpacker, predictor, pixel ring memory and group output register
module pckdec_datapath
  import pckdec_pkg::*;
#(
  parameter int unsigned MAX_ROW_WIDTH = MaxRowWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [7:0]          stream_byte_i,
  input  logic                new_image_i,
  input  pck_cmd_t            cmd_i,
  output pck_stat_t           stat_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [15:0]         pixel_a_o,
  output logic [15:0]         pixel_b_o,
  output logic [15:0]         pixel_c_o,
  output logic [15:0]         pixel_d_o,
  output logic [2:0]          pixel_count_o,
  output logic                last_of_byte_o,
  output logic                image_done_o
);

  localparam int unsigned Depth = MAX_ROW_WIDTH + 1;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned OW    = AW + 1;
  localparam logic [OW-1:0] DepthW = OW'(Depth);
  localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);

  // configuration
  logic [RowWidthW-1:0] row_q;
  logic [TotalW-1:0]    total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= RowWidthRst;
      total_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROW_WIDTH:    row_q   <= cfg_data_i[RowWidthW-1:0];
        CFG_TOTAL_PIXELS: total_q <= cfg_data_i[TotalW-1:0];
        default: ;
      endcase
    end
  end

  // clamped row width
  logic [OW-1:0] w_eff;
  always_comb begin
    if (row_q == '0) begin
      w_eff = OW'(1);
    end else if ({1'b0, row_q} > 14'(MAX_ROW_WIDTH)) begin
      w_eff = OW'(MAX_ROW_WIDTH);
    end else begin
      w_eff = OW'(row_q);
    end
  end

  // decoder state
  logic [7:0]        held_q;
  logic [3:0]        cnt_q;
  logic [31:0]       accum_q;
  logic [5:0]        need_q;
  logic [5:0]        width_q;
  logic              in_hdr_q;
  logic [7:0]        run_q;
  logic [TotalW-1:0] done_q;
  logic              pend_q;
  logic [15:0]       delta_q;
  logic [15:0]       prev_q;
  logic [AW-1:0]     wp_q;
  logic [15:0]       nbr_q [3];
  logic [15:0]       grp_q [4];
  logic [2:0]        grp_n_q;
  logic              grp_done_q;

  // bit step
  logic [5:0]  need_eff, need_new;
  logic [31:0] accum_new;
  logic [15:0] sext;
  always_comb begin
    need_eff  = (need_q == '0 || need_q > width_q) ? width_q : need_q;
    need_new  = need_eff - 6'd1;
    accum_new = accum_q | ({31'd0, held_q[0]} << 5'(width_q - need_eff));
    case (width_q)
      6'd4:    sext = {{12{accum_new[3]}}, accum_new[3:0]};
      6'd5:    sext = {{11{accum_new[4]}}, accum_new[4:0]};
      6'd6:    sext = {{10{accum_new[5]}}, accum_new[5:0]};
      6'd7:    sext = {{9{accum_new[6]}}, accum_new[6:0]};
      6'd8:    sext = {{8{accum_new[7]}}, accum_new[7:0]};
      default: sext = accum_new[15:0];
    endcase
  end

  // neighbour address in the ring
  logic [OW-1:0] off, wp_ext;
  logic [AW-1:0] rd_addr;
  always_comb begin
    case (cmd_i.rd_idx)
      NBR_A:   off = w_eff + OW'(1);
      NBR_B:   off = w_eff;
      default: off = w_eff - OW'(1);
    endcase
    wp_ext = {1'b0, wp_q};
    if (wp_ext >= off) begin
      rd_addr = AW'(wp_ext - off);
    end else begin
      rd_addr = AW'(wp_ext + DepthW - off);
    end
  end

  // ring memory
  logic [15:0] mem [Depth];
  logic [15:0] rd_data_q;
  logic [15:0] pix;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_data_q <= mem[rd_addr];
    end
    if (cmd_i.emit) begin
      mem[wp_q] <= pix;
    end
  end

  // prediction and pixel value
  logic signed [18:0] sum;
  logic signed [18:0] avg;
  logic [15:0]        pred, c_val;
  logic [15:0]        delta;
  always_comb begin
    c_val = (w_eff >= OW'(2)) ? nbr_q[2] : 16'd0;
    sum = 19'(signed'(nbr_q[0])) + 19'(signed'(nbr_q[1])) + 19'(signed'(c_val))
        + 19'(signed'(prev_q)) + 19'sd2;
    avg = (sum < 0) ? ((sum + 19'sd3) >>> 2) : (sum >>> 2);
    if (stat_o.need_nbr) begin
      pred = avg[15:0];
    end else if (done_q != '0) begin
      pred = prev_q;
    end else begin
      pred = 16'd0;
    end
    delta = pend_q ? delta_q : 16'd0;
    pix   = pred + delta;
  end

  // status
  logic push_full;
  logic [TotalW:0] done_inc;
  assign done_inc          = {1'b0, done_q} + (TotalW+1)'(1);
  assign stat_o.complete   = (done_q >= total_q);
  assign stat_o.bits_left  = (cnt_q != '0);
  assign stat_o.pix_req    = pend_q || (!in_hdr_q && width_q == '0);
  assign stat_o.need_nbr   = ({{(TotalW+1-OW){1'b0}}, w_eff} < {1'b0, done_q});
  assign stat_o.grp_full   = (grp_n_q == 3'd4);
  assign stat_o.grp_empty  = (grp_n_q == '0);
  assign stat_o.out_free   = !out_valid_o || out_ready_i;
  assign push_full         = cmd_i.emit && stat_o.grp_full;

  // decoder control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q     <= '0;
      cnt_q      <= '0;
      accum_q    <= '0;
      need_q     <= 6'(HeaderBits);
      width_q    <= 6'(HeaderBits);
      in_hdr_q   <= 1'b1;
      run_q      <= '0;
      done_q     <= '0;
      pend_q     <= 1'b0;
      wp_q       <= '0;
      grp_n_q    <= '0;
      grp_done_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        if (new_image_i) begin
          accum_q  <= '0;
          need_q   <= 6'(HeaderBits);
          width_q  <= 6'(HeaderBits);
          in_hdr_q <= 1'b1;
          run_q    <= '0;
          done_q   <= '0;
          pend_q   <= 1'b0;
          wp_q     <= '0;
        end
        held_q     <= stream_byte_i;
        cnt_q      <= 4'd8;
        grp_n_q    <= '0;
        grp_done_q <= 1'b0;
      end
      // consume one bit
      if (cmd_i.bit_step) begin
        held_q <= {1'b0, held_q[7:1]};
        cnt_q  <= cnt_q - 4'd1;
        if (need_new == '0) begin
          accum_q <= '0;
          if (in_hdr_q) begin
            in_hdr_q <= 1'b0;
            run_q    <= 8'd1 << accum_new[2:0];
            width_q  <= field_width_of(accum_new[5:3]);
            need_q   <= field_width_of(accum_new[5:3]);
          end else begin
            need_q <= width_q;
            pend_q <= 1'b1;
          end
        end else begin
          accum_q <= accum_new;
          need_q  <= need_new;
        end
      end
      // emit one pixel
      if (cmd_i.emit) begin
        pend_q <= 1'b0;
        done_q <= done_inc[TotalW-1:0];
        wp_q   <= (wp_q == LastIdx) ? '0 : wp_q + AW'(1);
        if (run_q <= 8'd1) begin
          run_q    <= '0;
          in_hdr_q <= 1'b1;
          width_q  <= 6'(HeaderBits);
          need_q   <= 6'(HeaderBits);
        end else begin
          run_q <= run_q - 8'd1;
        end
        grp_n_q    <= stat_o.grp_full ? 3'd1 : grp_n_q + 3'd1;
        grp_done_q <= (done_inc >= {1'b0, total_q});
      end
      if (cmd_i.flush_last) begin
        grp_n_q <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.bit_step && need_new == '0 && !in_hdr_q) begin
      delta_q <= sext;
    end
    if (cmd_i.cap) begin
      nbr_q[0] <= nbr_q[1];
      nbr_q[1] <= nbr_q[2];
      nbr_q[2] <= rd_data_q;
    end
    if (cmd_i.emit) begin
      prev_q <= pix;
      if (stat_o.grp_full) begin
        grp_q[0] <= pix;
      end else begin
        grp_q[grp_n_q[1:0]] <= pix;
      end
    end
  end

  // output register
  logic out_valid_q;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push_full || cmd_i.flush_last) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_full || cmd_i.flush_last) begin
      pixel_a_o      <= grp_q[0];
      pixel_b_o      <= (grp_n_q >= 3'd2) ? grp_q[1] : 16'd0;
      pixel_c_o      <= (grp_n_q >= 3'd3) ? grp_q[2] : 16'd0;
      pixel_d_o      <= (grp_n_q >= 3'd4) ? grp_q[3] : 16'd0;
      pixel_count_o  <= grp_n_q;
      last_of_byte_o <= cmd_i.flush_last;
      image_done_o   <= cmd_i.flush_last && grp_done_q;
    end
  end

endmodule

// ===== rtl/pck_image_decompressor_core.sv =====
// top level of the packed detector image decompressor
// Takes one compressed byte per request and returns groups of up to four decoded
// 16-bit pixels, the last group of each byte marked. The controller accepts a
// byte, steps its bits one at a time through the bit unpacker, then closes the
// byte's scan and sends its final group. A pixel in the first row plus one
// pixel is emitted directly; beyond it, the three upper neighbours are first
// read one after another through the single read port of the pixel ring memory
// (MAX_ROW_WIDTH + 1 entries). A byte that opens zero-width runs may yield up to
// 256 pixels, so the byte side stalls for that long; a stalled group channel
// holds the decoder as well. Configuration must be written only while no byte
// is in flight (left to the user); new_image restarts the decode at pixel 0.
module pck_image_decompressor_core
  import pckdec_pkg::*;
#(
  parameter int unsigned MAX_ROW_WIDTH = MaxRowWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  pck_byte_if.sink            in_if,
  pck_group_if.source         out_if
);

  pck_cmd_t  cmd;
  pck_stat_t stat;

  // sequencer
  pckdec_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath
  pckdec_datapath #(
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .stream_byte_i  (in_if.stream_byte),
    .new_image_i    (in_if.new_image),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (out_if.valid),
    .out_ready_i    (out_if.ready),
    .pixel_a_o      (out_if.pixel_a),
    .pixel_b_o      (out_if.pixel_b),
    .pixel_c_o      (out_if.pixel_c),
    .pixel_d_o      (out_if.pixel_d),
    .pixel_count_o  (out_if.pixel_count),
    .last_of_byte_o (out_if.last_of_byte),
    .image_done_o   (out_if.image_done)
  );

endmodule

// ===== sim/tb_pck_image_decompressor_core.sv =====
// self-checking testbench of the packed detector image decompressor core
module tb_pck_image_decompressor_core;
  import pckdec_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RingDepth = MaxRowWidthDef + 1;
  localparam int unsigned MaxGroups = 64;

  typedef struct {
    logic [15:0] pa, pb, pc, pd;
    logic [2:0]  cnt;
    logic        last;
    logic        done;
  } pixel_group_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  pck_byte_if in_if ();
  pck_group_if out_if ();

  pck_image_decompressor_core dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_if (in_if.sink),
    .out_if (out_if.source)
  );

  always #10 clk_i = ~clk_i;

  // decoder model state
  int unsigned row_w = RowWidthRst;
  int unsigned total_px = 0;
  int unsigned f_accum = 0, f_need = HeaderBits, f_width = HeaderBits;
  bit          in_hdr = 1'b1;
  int unsigned run_left = 0, px_done = 0;
  logic [15:0] pix_ring [RingDepth];
  logic [15:0] grp [4];
  int unsigned grp_n, byte_groups;
  pixel_group_t pending_groups [$];

  int unsigned fails = 0, groups_seen = 0, bytes_sent = 0, images = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  // bit packer for hand-built streams
  logic [7:0] pk_acc;
  int unsigned pk_n = 0;
  bit pk_first = 1'b0;

  function automatic bit img_complete();
    return px_done >= total_px;
  endfunction

  function automatic int sx16(logic [15:0] v);
    return int'($signed(v));
  endfunction

  function automatic int unsigned width_of_code(int unsigned c);
    int unsigned wt [8] = '{0, 4, 5, 6, 7, 8, 16, 32};
    return wt[c];
  endfunction

  task automatic clear_decoder();
    f_accum = 0;
    f_need = HeaderBits;
    f_width = HeaderBits;
    in_hdr = 1'b1;
    run_left = 0;
    px_done = 0;
    images++;
  endtask

  task automatic push_group(bit done);
    pixel_group_t g;
    if (grp_n == 0 || byte_groups >= MaxGroups) return;
    g.pa = grp[0];
    g.pb = (grp_n > 1) ? grp[1] : '0;
    g.pc = (grp_n > 2) ? grp[2] : '0;
    g.pd = (grp_n > 3) ? grp[3] : '0;
    g.cnt = 3'(grp_n);
    g.last = 1'b0;
    g.done = done;
    pending_groups.push_back(g);
    byte_groups++;
    grp_n = 0;
  endtask

  // one pixel: prediction from neighbours plus delta
  task automatic decode_pixel(int unsigned delta);
    int unsigned i, w;
    int a, b, c, d, pred;
    logic [15:0] pix;
    i = px_done;
    w = (row_w == 0) ? 1 : (row_w > MaxRowWidthDef ? MaxRowWidthDef : row_w);
    if (i > w) begin
      a = sx16(pix_ring[(i + RingDepth - w - 1) % RingDepth]);
      b = sx16(pix_ring[(i + RingDepth - w) % RingDepth]);
      c = (w >= 2) ? sx16(pix_ring[(i + RingDepth - w + 1) % RingDepth]) : 0;
      d = sx16(pix_ring[(i + RingDepth - 1) % RingDepth]);
      pred = (a + b + c + d + 2) / 4;
    end else if (i > 0) begin
      pred = int'(pix_ring[(i + RingDepth - 1) % RingDepth]);
    end else begin
      pred = 0;
    end
    pix = 16'(pred + int'(delta));
    pix_ring[i % RingDepth] = pix;
    px_done = (i + 1) & 32'h1ff_ffff;
    if (run_left > 0) run_left--;
    if (run_left == 0) begin
      in_hdr = 1'b1;
      f_width = HeaderBits;
      f_need = HeaderBits;
    end
    grp[grp_n] = pix;
    grp_n++;
    if (img_complete()) push_group(1'b1);
    else if (grp_n == 4) push_group(1'b0);
  endtask

  // expected pixel groups of one request
  task automatic decode_byte(logic [7:0] sb, bit ni);
    int unsigned v, h;
    bit bt;
    byte_groups = 0;
    grp_n = 0;
    if (ni) clear_decoder();
    if (img_complete()) return;
    for (int k = 0; k < 8 && !img_complete(); k++) begin
      bt = sb[k];
      if (f_need == 0 || f_need > f_width) f_need = f_width;
      f_accum |= int'(bt) << (f_width - f_need);
      f_need--;
      if (f_need != 0) continue;
      if (in_hdr) begin
        h = f_accum;
        f_accum = 0;
        in_hdr = 1'b0;
        run_left = 1 << (h & 7);
        f_width = width_of_code((h >> 3) & 7);
        f_need = f_width;
        while (!in_hdr && f_width == 0 && !img_complete()) decode_pixel(0);
      end else begin
        v = f_accum;
        if (f_width < 32 && v[f_width-1]) v |= ~((32'd1 << f_width) - 1);
        f_accum = 0;
        f_need = f_width;
        decode_pixel(v);
      end
    end
    push_group(1'b0);
    if (byte_groups > 0) pending_groups[$].last = 1'b1;
  endtask

  // one compressed byte request, with random gaps before it
  task automatic send_byte(logic [7:0] sb, bit ni);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    decode_byte(sb, ni);
    in_if.valid <= 1'b1;
    in_if.stream_byte <= sb;
    in_if.new_image <= ni;
    do @(posedge clk_i); while (!in_if.ready);
    bytes_sent++;
  endtask

  task automatic put_bits(logic [31:0] val, int unsigned n);
    for (int k = 0; k < n; k++) begin
      pk_acc[pk_n] = val[k];
      pk_n++;
      if (pk_n == 8) begin
        send_byte(pk_acc, pk_first);
        pk_first = 1'b0;
        pk_n = 0;
      end
    end
  endtask

  task automatic pad_bits();
    if (pk_n > 0) put_bits(32'd0, 8 - pk_n);
  endtask

  // block idle: everything delivered, then let it settle
  task automatic wait_idle();
    int unsigned guard;
    guard = 0;
    in_if.valid <= 1'b0;
    while (pending_groups.size() > 0 && guard < 400000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= CfgDataW'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_ROW_WIDTH) row_w = val & 32'h1fff;
    else total_px = val & 32'h1ff_ffff;
  endtask

  task automatic set_image(int unsigned rw, int unsigned tot);
    wait_idle();
    write_reg(CFG_ROW_WIDTH, rw);
    write_reg(CFG_TOTAL_PIXELS, tot);
  endtask

  // field extremes, every field width and zero-width runs
  task automatic test_field_extremes();
    send_byte(8'hff, 1'b1);
    send_byte(8'h00, 1'b0);
    set_image(4, 200);
    pk_first = 1'b1;
    put_bits(6'b111_000, 6); put_bits(32'hffff_ffff, 32);
    put_bits(6'b111_000, 6); put_bits(32'h8000_0000, 32);
    put_bits(6'b110_001, 6); put_bits(16'h8000, 16); put_bits(16'h7fff, 16);
    put_bits(6'b001_001, 6);
    put_bits(4'h8, 4); put_bits(4'h7, 4);
    put_bits(4'hf, 4); put_bits(4'h0, 4);
    put_bits(6'b010_000, 6); put_bits(5'h10, 5);
    put_bits(6'b011_000, 6); put_bits(6'h3f, 6);
    put_bits(6'b100_000, 6); put_bits(7'h40, 7);
    put_bits(6'b101_000, 6); put_bits(8'h80, 8);
    put_bits(6'b000_011, 6);
    put_bits(6'b000_111, 6);
    pad_bits();
    send_byte(8'h5a, 1'b0);
  endtask

  // neighbour offset edge cases and ring wrap at the widest row
  task automatic test_row_widths();
    logic [7:0] zr [3] = '{8'hc7, 8'h71, 8'h1c};
    set_image(0, 60);
    for (int k = 0; k < 8; k++) send_byte(8'($urandom), k == 0);
    set_image(1, 60);
    for (int k = 0; k < 8; k++) send_byte(8'($urandom), k == 0);
    set_image(8191, 150);
    for (int k = 0; k < 10; k++) send_byte(8'($urandom), k == 0);
    set_image(4096, 4700);
    pk_first = 1'b1;
    for (int k = 0; k < 6; k++) begin
      put_bits(6'b011_000, 6); put_bits($urandom, 6);
    end
    for (int k = 0; k < 30; k++) send_byte(zr[k % 3], 1'b0);
    for (int k = 0; k < 8; k++) send_byte(8'($urandom), 1'b0);
  endtask

  // image completing inside a byte, ignored bytes, restart mid image
  task automatic test_image_end();
    set_image(3, 5);
    for (int k = 0; k < 6; k++) send_byte(8'($urandom), k == 0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h3f, 1'b0);
    set_image(2, 40);
    for (int k = 0; k < 4; k++) send_byte(8'($urandom), k == 0);
    send_byte(8'($urandom), 1'b1);
    send_byte(8'($urandom), 1'b0);
    wait_idle();
    write_reg(CFG_TOTAL_PIXELS, 0);
    send_byte(8'($urandom), 1'b1);
  endtask

  // output side held off long enough to fill the block
  task automatic test_backpressure();
    set_image(5, 2000);
    hold_req = 1'b1;
    for (int k = 0; k < 30; k++) send_byte(8'($urandom), k == 0);
  endtask

  // random images with random row widths and sizes
  task automatic test_random();
    int unsigned rw, tot;
    for (int ph = 0; ph < 9; ph++) begin
      case ($urandom_range(0, 5))
        0: rw = $urandom_range(0, 8191);
        1: rw = $urandom_range(40, 300);
        default: rw = $urandom_range(1, 20);
      endcase
      tot = ($urandom_range(0, 9) == 0) ? 16777216 : $urandom_range(1, 300);
      if (ph == 8) calm = 1'b1;
      set_image(rw, tot);
      for (int k = 0; k < 30; k++)
        send_byte(8'($urandom), k == 0 || $urandom_range(0, 24) == 0);
    end
  endtask

  // output ready with random stalls and the long hold-off
  initial begin
    int unsigned n;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        n = 0;
        while (n < 600) begin
          @(posedge clk_i);
          n++;
        end
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // compare every delivered group with the oldest expectation
  always @(posedge clk_i) begin
    pixel_group_t g;
    if (rst_ni && out_if.valid && out_if.ready) begin
      groups_seen++;
      if (pending_groups.size() == 0) begin
        $error("unexpected pixel group, pixel_a %0d", out_if.pixel_a);
        fails++;
      end else begin
        g = pending_groups.pop_front();
        if (out_if.pixel_a !== g.pa) begin
          $error("pixel_a: expected %0d, actual %0d", g.pa, out_if.pixel_a); fails++;
        end
        if (out_if.pixel_b !== g.pb) begin
          $error("pixel_b: expected %0d, actual %0d", g.pb, out_if.pixel_b); fails++;
        end
        if (out_if.pixel_c !== g.pc) begin
          $error("pixel_c: expected %0d, actual %0d", g.pc, out_if.pixel_c); fails++;
        end
        if (out_if.pixel_d !== g.pd) begin
          $error("pixel_d: expected %0d, actual %0d", g.pd, out_if.pixel_d); fails++;
        end
        if (out_if.pixel_count !== g.cnt) begin
          $error("pixel_count: expected %0d, actual %0d", g.cnt, out_if.pixel_count);
          fails++;
        end
        if (out_if.last_of_byte !== g.last) begin
          $error("last_of_byte: expected %0d, actual %0d", g.last, out_if.last_of_byte);
          fails++;
        end
        if (out_if.image_done !== g.done) begin
          $error("image_done: expected %0d, actual %0d", g.done, out_if.image_done);
          fails++;
        end
      end
    end
  end

  // timeout
  initial begin
    #40ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // main sequence
  initial begin
    in_if.valid = 1'b0;
    in_if.stream_byte = '0;
    in_if.new_image = 1'b0;
    for (int k = 0; k < RingDepth; k++) pix_ring[k] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_field_extremes();
    test_row_widths();
    test_image_end();
    test_backpressure();
    test_random();
    wait_idle();
    if (pending_groups.size() > 0) begin
      $error("%0d expected pixel groups never arrived", pending_groups.size());
      fails++;
    end
    $display("sent %0d compressed bytes over %0d images, checked %0d pixel groups",
             bytes_sent, images, groups_seen);
    $display("covered all field widths, zero-width runs, row width edges and stalls");
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pckdec_pkg.sv
rtl/pck_stream_if.sv
rtl/pckdec_ctrl.sv
rtl/pckdec_datapath.sv
rtl/pck_image_decompressor_core.sv
sim/tb_pck_image_decompressor_core.sv
